### rtl/core/rc5_pkg.sv
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared constants, types and helper functions for the RC5-32/12/16 block.
// ----------------------------------------------------------------------------
package rc5_pkg;

    localparam int unsigned ROUNDS      = 12;
    localparam int unsigned TABLE_WORDS = 2 * (ROUNDS + 1);
    localparam int unsigned KEY_WORDS   = 4;
    localparam int unsigned MIX_STEPS   =
        3 * ((TABLE_WORDS > KEY_WORDS) ? TABLE_WORDS : KEY_WORDS);
    localparam int unsigned TW_BITS     = $clog2(TABLE_WORDS);
    localparam int unsigned KW_BITS     = $clog2(KEY_WORDS);
    localparam int unsigned RND_BITS    = $clog2(ROUNDS + 1);
    localparam int unsigned MIX_BITS    = $clog2(MIX_STEPS + 1);

    localparam logic [31:0] MAGIC_P = 32'hB7E1_5163;
    localparam logic [31:0] MAGIC_Q = 32'h9E37_79B9;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    // Handoff from the cell in front to the next one.
    typedef struct packed {
        logic        act;
        logic [31:0] a;
        logic [31:0] b;
    } t_cell_data;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} << n;
        return w[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} >> n;
        return w[31:0];
    endfunction

endpackage

### rtl/core/rc5_key_expand.sv
// ----------------------------------------------------------------------------
// rc5_key_expand
// Fills the round-key table with the P/Q progression, then runs the
// mixing steps, one per cycle, over the table and a copy of the key.
// ----------------------------------------------------------------------------
module rc5_key_expand (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_key [rc5_pkg::KEY_WORDS],
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_table [rc5_pkg::TABLE_WORDS]
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FILL = 3'b010,
        S_MIX  = 3'b100
    } t_state;

    t_state                          r_state;
    logic [31:0]                     r_s [rc5_pkg::TABLE_WORDS];
    logic [31:0]                     r_l [rc5_pkg::KEY_WORDS];
    logic [31:0]                     r_a;
    logic [31:0]                     r_b;
    logic [rc5_pkg::TW_BITS-1:0]     r_i;
    logic [rc5_pkg::KW_BITS-1:0]     r_j;
    logic [rc5_pkg::MIX_BITS-1:0]    r_cnt;
    logic [31:0]                     n_a;
    logic [31:0]                     n_b;
    logic [31:0]                     r_fill;

    always_comb begin
        n_a = rc5_pkg::rotl32(r_s[r_i] + r_a + r_b, 5'd3);
        n_b = rc5_pkg::rotl32(r_l[r_j] + n_a + r_b, 5'(n_a + r_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_FILL;
                        r_i     <= '0;
                        r_fill  <= rc5_pkg::MAGIC_P;
                        r_l     <= i_key;
                    end
                end
                S_FILL: begin
                    r_s[r_i] <= r_fill;
                    r_fill   <= r_fill + rc5_pkg::MAGIC_Q;
                    if (r_i == rc5_pkg::TW_BITS'(rc5_pkg::TABLE_WORDS - 1)) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_a     <= '0;
                        r_b     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MIX;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_MIX: begin
                    r_s[r_i] <= n_a;
                    r_l[r_j] <= n_b;
                    r_a      <= n_a;
                    r_b      <= n_b;
                    r_j      <= r_j + 1'b1;
                    r_i      <= (r_i == rc5_pkg::TW_BITS'(rc5_pkg::TABLE_WORDS - 1)) ?
                                '0 : r_i + 1'b1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == rc5_pkg::MIX_BITS'(rc5_pkg::MIX_STEPS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = (r_state == S_MIX) &&
                     (r_cnt == rc5_pkg::MIX_BITS'(rc5_pkg::MIX_STEPS - 1));
    assign o_table = r_s;

endmodule

### rtl/core/rc5_round_cell.sv
// ----------------------------------------------------------------------------
// rc5_round_cell
// One RC5 round, forward or inverse, with a register on its output.
// ----------------------------------------------------------------------------
module rc5_round_cell (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [31:0]         i_k0,
    input  logic [31:0]         i_k1,
    input  rc5_pkg::t_cell_data i_data,
    output rc5_pkg::t_cell_data o_data
);

    rc5_pkg::t_cell_data r_data;
    rc5_pkg::t_cell_data n_data;
    logic [31:0]         w_a;
    logic [31:0]         w_b;

    always_comb begin
        n_data.act = i_data.act;
        if (i_data.act == rc5_pkg::ACT_ENCRYPT) begin
            w_a = rc5_pkg::rotl32(i_data.a ^ i_data.b, i_data.b[4:0]) + i_k0;
            w_b = rc5_pkg::rotl32(i_data.b ^ w_a, w_a[4:0]) + i_k1;
        end else begin
            w_b = rc5_pkg::rotr32(i_data.b - i_k1, i_data.a[4:0]) ^ i_data.a;
            w_a = rc5_pkg::rotr32(i_data.a - i_k0, w_b[4:0]) ^ w_b;
        end
        n_data.a = w_a;
        n_data.b = w_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

### rtl/core/rc5_block_cipher.sv
// ----------------------------------------------------------------------------
// rc5_block_cipher
// RC5-32/12/16 encrypt/decrypt engine built as a chain of round cells.
// ----------------------------------------------------------------------------
//  channel | dir | signals                           | contents
//  s_axis  | in  | tvalid tready tdata[63:0] tuser   | block_a, block_b; tuser=action
//  m_axis  | out | tvalid tready tdata[63:0]         | result_a, result_b
//  cfg     | in  | i_cfg_we i_cfg_idx[1:0] i_cfg_data| key words 0..3
//
// Flow: one item runs through the chain of ROUNDS round cells, one cell a
// cycle, from the entry stage (whitening) through the cells into the output
// register; one item is in the chain at a time, set by the single
// occupancy bit of the cell chain. The first item after reset or after a key
// write waits for expansion: a start request, TABLE_WORDS fill steps, then
// MIX_STEPS mix steps (26 + 78). Reset clears control and the key words.
// A stalled output holds the result register; the next item is taken once
// the result is delivered.
// ----------------------------------------------------------------------------
module rc5_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] block_a, [63:32] block_b
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] result_a, [63:32] result_b
);

    localparam int unsigned NR = rc5_pkg::ROUNDS;

    logic [31:0]                  r_key [rc5_pkg::KEY_WORDS];
    logic                         r_ready_tbl;
    logic                         r_start;
    logic                         r_redo;
    logic                         w_busy;
    logic                         w_done;
    logic [31:0]                  w_tbl [rc5_pkg::TABLE_WORDS];
    logic                         r_busy;
    logic [rc5_pkg::RND_BITS-1:0] r_step;
    logic                         r_out_v;
    logic [63:0]                  r_out;
    rc5_pkg::t_cell_data          r_in;
    rc5_pkg::t_cell_data          w_chain [NR+1];
    logic                         w_acc;
    logic                         w_act;

    // Hold key registers; drop table validity on any key write. A write that
    // lands while an expansion runs marks that expansion stale.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_tbl <= 1'b0;
            r_start     <= 1'b0;
            r_redo      <= 1'b0;
            for (int k = 0; k < rc5_pkg::KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
        end else begin
            r_start <= 1'b0;
            if (i_cfg_we) begin
                r_key[i_cfg_idx] <= i_cfg_data;
                r_ready_tbl      <= 1'b0;
                if (w_busy || r_start) begin
                    r_redo <= 1'b1;
                end
            end else if (w_done) begin
                r_ready_tbl <= !r_redo;
            end else if (!r_ready_tbl && !w_busy && !r_start && s_axis_tvalid) begin
                r_start <= 1'b1;
                r_redo  <= 1'b0;
            end
        end
    end

    rc5_key_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_key   (r_key),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_table (w_tbl)
    );

    assign s_axis_tready = r_ready_tbl && !r_busy && !r_out_v && !i_cfg_we;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_act         = s_axis_tuser;

    // Entry stage: whitening for encrypt; decrypt enters raw.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in.act <= w_act;
            if (w_act == rc5_pkg::ACT_ENCRYPT) begin
                r_in.a <= s_axis_tdata[31:0] + w_tbl[0];
                r_in.b <= s_axis_tdata[63:32] + w_tbl[1];
            end else begin
                r_in.a <= s_axis_tdata[31:0];
                r_in.b <= s_axis_tdata[63:32];
            end
        end
    end

    assign w_chain[0] = r_in;

    // Cell c runs round c+1 for encrypt and round NR-c for decrypt.
    for (genvar c = 0; c < NR; c++) begin : g_cell
        logic [31:0] w_k0;
        logic [31:0] w_k1;
        assign w_k0 = (w_chain[c].act == rc5_pkg::ACT_ENCRYPT) ?
                      w_tbl[2*(c+1)] : w_tbl[2*(NR-c)];
        assign w_k1 = (w_chain[c].act == rc5_pkg::ACT_ENCRYPT) ?
                      w_tbl[2*(c+1)+1] : w_tbl[2*(NR-c)+1];
        rc5_round_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (1'b1),
            .i_k0   (w_k0),
            .i_k1   (w_k1),
            .i_data (w_chain[c]),
            .o_data (w_chain[c+1])
        );
    end

    // Advance the step count; capture the chain tail into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (w_acc) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == rc5_pkg::RND_BITS'(NR)) begin
                    r_busy  <= 1'b0;
                    r_out_v <= 1'b1;
                    if (w_chain[NR].act == rc5_pkg::ACT_ENCRYPT) begin
                        r_out <= {w_chain[NR].b, w_chain[NR].a};
                    end else begin
                        r_out <= {w_chain[NR].b - w_tbl[1], w_chain[NR].a - w_tbl[0]};
                    end
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_no_acc_unready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> r_ready_tbl && !w_busy)
        else $error("item accepted without a ready key table");
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready)
        else $error("input ready while an item is in the chain");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
`endif

endmodule

### verif/rc5_block_cipher_checker.sv
// ----------------------------------------------------------------------------
// rc5_block_cipher_checker
// Watches the key port and both streams, computes each transformed block
// from its own key schedule and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module rc5_block_cipher_checker
    import rc5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic        i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] key_copy [KEY_WORDS];
    logic [31:0] sched [TABLE_WORDS];
    logic        sched_valid;
    logic [63:0] block_queue [$];

    function automatic logic [31:0] rol(input logic [31:0] v, input logic [31:0] n);
        logic [4:0] s;
        s = n[4:0];
        return (s == 0) ? v : ((v << s) | (v >> (6'd32 - s)));
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] v, input logic [31:0] n);
        logic [4:0] s;
        s = n[4:0];
        return (s == 0) ? v : ((v >> s) | (v << (6'd32 - s)));
    endfunction

    task automatic build_schedule();
        logic [31:0] l [KEY_WORDS];
        logic [31:0] x, y;
        int ti, kj;
        x = 0; y = 0; ti = 0; kj = 0;
        for (int k = 0; k < KEY_WORDS; k++) l[k] = key_copy[k];
        sched[0] = MAGIC_P;
        for (int k = 1; k < TABLE_WORDS; k++) sched[k] = sched[k-1] + MAGIC_Q;
        for (int k = 0; k < MIX_STEPS; k++) begin
            x = rol(sched[ti] + x + y, 3);
            sched[ti] = x;
            y = rol(l[kj] + x + y, x + y);
            l[kj] = y;
            ti = (ti + 1) % TABLE_WORDS;
            kj = (kj + 1) % KEY_WORDS;
        end
        sched_valid = 1'b1;
    endtask

    function automatic logic [63:0] transform(input logic dec, input logic [63:0] d);
        logic [31:0] a, b;
        a = d[31:0];
        b = d[63:32];
        if (dec == ACT_ENCRYPT) begin
            a += sched[0];
            b += sched[1];
            for (int r = 1; r <= ROUNDS; r++) begin
                a = rol(a ^ b, b) + sched[2*r];
                b = rol(b ^ a, a) + sched[2*r+1];
            end
        end else begin
            for (int r = ROUNDS; r >= 1; r--) begin
                b = ror(b - sched[2*r+1], a) ^ a;
                a = ror(a - sched[2*r], b) ^ b;
            end
            b -= sched[1];
            a -= sched[0];
        end
        return {b, a};
    endfunction

    assign o_pending = block_queue.size();

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++) key_copy[k] = '0;
            sched_valid = 1'b0;
            block_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                key_copy[i_cfg_idx] = i_cfg_data;
                sched_valid = 1'b0;
            end
            if (i_in_valid && i_in_ready) begin
                if (!sched_valid) build_schedule();
                block_queue.push_back(transform(i_in_user, i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (block_queue.size() == 0) begin
                    $error("result_a/result_b: unexpected item %h", i_out_data);
                    o_fail_count++;
                end else begin
                    want = block_queue.pop_front();
                    if (want[31:0] !== i_out_data[31:0]) begin
                        $error("result_a: expected %h actual %h", want[31:0],
                               i_out_data[31:0]);
                        o_fail_count++;
                    end
                    if (want[63:32] !== i_out_data[63:32]) begin
                        $error("result_b: expected %h actual %h", want[63:32],
                               i_out_data[63:32]);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

### verif/rc5_block_cipher_tb.sv
// ----------------------------------------------------------------------------
// rc5_block_cipher_tb
// Drives key words and blocks with bursty input and a stalling receiver,
// including a long receiver hold-off; the checker predicts every result.
// ----------------------------------------------------------------------------
module rc5_block_cipher_tb;
    import rc5_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_TAIL = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] block_a, [63:32] block_b
    logic        s_axis_tuser;   // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [31:0] result_a, [63:32] result_b
    int          fail_count;
    int          pending;
    bit          hold_off;       // forces the receiver to stall
    logic [63:0] recent [$];     // recent input blocks, reused as later inputs

    rc5_block_cipher dut (.*);

    rc5_block_cipher_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Receiver: its own stall pattern, with calm stretches and a forced hold.
    initial begin
        int mode;
        m_axis_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(5, 40)) begin
                @(negedge i_clk);
                if (hold_off) m_axis_tready <= 1'b0;
                else if (mode == 0) m_axis_tready <= 1'b1;
                else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
                else m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Offer one item and hold it until accepted; pause_sender adds random idle gaps.
    task automatic send_block(input logic act, input logic [31:0] a, input logic [31:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        recent.push_back({b, a});
        if (recent.size() > 16) void'(recent.pop_front());
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge i_clk);
    endtask

    // Drain results, let the block settle, then write a key word.
    task automatic write_key(input logic [1:0] idx, input logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (ROUNDS + 4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_key(input logic [127:0] k);
        for (int w = 0; w < KEY_WORDS; w++) write_key(w[1:0], k[32*w +: 32]);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [63:0] pick;
        int burst;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_ENCRYPT;
        hold_off = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset key, extremes and both actions.
        send_block(ACT_ENCRYPT, '0, '0);
        send_block(ACT_ENCRYPT, '1, '1);
        send_block(ACT_DECRYPT, '0, '0);
        send_block(ACT_DECRYPT, '1, '1);
        send_block(ACT_ENCRYPT, 32'h8000_0000, 32'h0000_001f);
        load_key('1);
        send_block(ACT_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
        send_block(ACT_DECRYPT, 32'h0123_4567, 32'h89ab_cdef);
        // A single word change must force a fresh schedule.
        write_key(2'd2, 32'h0000_0001);
        send_block(ACT_ENCRYPT, 32'h5555_5555, 32'haaaa_aaaa);
        send_block(ACT_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555);
        load_key(128'h0);
        send_block(ACT_ENCRYPT, '0, '0);
        send_block(ACT_ENCRYPT, 32'h0000_0001, 32'h0000_0000);

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (8) send_block(1'($urandom_range(0, 1)), $urandom(), $urandom());
        join

        // Random phases with a new key for each.
        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 3) load_key(128'h0);
            else if (phase == 6) load_key('1);
            else if ((phase % 2) == 1) write_key(2'($urandom_range(0, 3)), $urandom());
            else load_key({$urandom(), $urandom(), $urandom(), $urandom()});
            for (int n = 0; n < 100; n++) begin
                burst = $urandom_range(0, 7);
                if (burst == 0) pause_sender();
                if (recent.size() != 0 && $urandom_range(0, 3) == 0) begin
                    pick = recent[$urandom_range(0, recent.size() - 1)];
                    send_block(1'($urandom_range(0, 1)), pick[31:0], pick[63:32]);
                end else begin
                    send_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (IDLE_TAIL) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far above the slowest correct run.
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
